### rtl/core/lsn_pkg.sv
// Shared types, constants and helper functions of the lidar scan point and normal block.
package lsn_pkg;

	localparam int RANGE_W = 16;
	localparam int ANG_W = 32;
	localparam int BEAM_W = 11;
	localparam int PT_W = 18;
	localparam int NRM_W = 16;
	localparam int OFF_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int IN_DATA_W = 16;
	localparam int OUT_DATA_W = 80;

	// window: four held points plus the newest one
	localparam int WIN_N = 5;
	localparam int WIN_IDX_W = 3;

	localparam logic [BEAM_W-1:0] BEAM_LAST = '1;

	localparam int CORDIC_STEPS = 30;
	localparam int STEP_W = 5;
	localparam int CW = 56;
	localparam int ZW = 34;
	localparam int VW = 20;
	localparam int DW = 19;
	localparam int GAP_W = 12;
	localparam logic signed [CW-1:0] CORDIC_K = 56'sd652032874;
	localparam logic [ANG_W-1:0] ANG_QUARTER_HALF = 32'h2000_0000;
	localparam logic [ANG_W-1:0] ANG_HALF_TURN = 32'h8000_0000;

	localparam logic signed [NRM_W-1:0] NRM_ONE = 16'sd16384;
	localparam logic signed [NRM_W-1:0] NRM_MONE = -16'sd16384;

	localparam logic [38:0] LIM_SQ_NEAR = 39'd62500;
	localparam logic [38:0] LIM_SQ_FAR = 39'd250000;

	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_START = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 3'd5;

	typedef struct packed {
		logic [RANGE_W-1:0] range_mm;
		logic               valid;
		logic               last;
		logic [ANG_W-1:0]   angle;
		logic [BEAM_W-1:0]  beam;
	} beam_item_t;

	typedef struct packed {
		logic signed [OFF_W-1:0] off_x;
		logic signed [OFF_W-1:0] off_y;
	} sensor_cfg_t;

	function automatic logic [ANG_W-1:0] atan_at(input logic [STEP_W-1:0] i);
		logic [ANG_W-1:0] a;
		case (i)
			5'd0: a = 32'h20000000;
			5'd1: a = 32'h12E4051E;
			5'd2: a = 32'h09FB385B;
			5'd3: a = 32'h051111D4;
			5'd4: a = 32'h028B0D43;
			5'd5: a = 32'h0145D7E1;
			5'd6: a = 32'h00A2F61E;
			5'd7: a = 32'h00517C55;
			5'd8: a = 32'h0028BE53;
			5'd9: a = 32'h00145F2F;
			5'd10: a = 32'h000A2F98;
			5'd11: a = 32'h000517CC;
			5'd12: a = 32'h00028BE6;
			5'd13: a = 32'h000145F3;
			5'd14: a = 32'h0000A2FA;
			5'd15: a = 32'h0000517D;
			5'd16: a = 32'h000028BE;
			5'd17: a = 32'h0000145F;
			5'd18: a = 32'h00000A30;
			5'd19: a = 32'h00000518;
			5'd20: a = 32'h0000028C;
			5'd21: a = 32'h00000146;
			5'd22: a = 32'h000000A3;
			5'd23: a = 32'h00000051;
			5'd24: a = 32'h00000029;
			5'd25: a = 32'h00000014;
			5'd26: a = 32'h0000000A;
			5'd27: a = 32'h00000005;
			5'd28: a = 32'h00000003;
			5'd29: a = 32'h00000001;
			default: a = '0;
		endcase
		return a;
	endfunction

	// round Q3.30 to Q1.14 and clamp to plus or minus one
	function automatic logic signed [NRM_W-1:0] to_q14(input logic signed [ZW-1:0] v);
		logic signed [ZW-1:0] t;
		logic signed [NRM_W-1:0] r;
		t = (v + 34'sd32768) >>> 16;
		if (t > 34'sd16384) begin
			r = NRM_ONE;
		end else if (t < -34'sd16384) begin
			r = NRM_MONE;
		end else begin
			r = t[NRM_W-1:0];
		end
		return r;
	endfunction

endpackage

### rtl/core/lsn_front.sv
// Front end: configuration registers, beam counting, range check and beam angle.
module lsn_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [lsn_pkg::IN_DATA_W-1:0]      s_tdata,
	input  logic                               s_tlast,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [lsn_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lsn_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               q_full,
	output logic                               q_push,
	output lsn_pkg::beam_item_t                q_item,
	output lsn_pkg::sensor_cfg_t               sensor
);
	import lsn_pkg::*;

	logic [RANGE_W-1:0] range_min_q, range_max_q;
	logic [ANG_W-1:0] angle_start_q, angle_step_q;
	logic signed [OFF_W-1:0] off_x_q, off_y_q;
	logic [BEAM_W-1:0] beam_q;
	logic [ANG_W+BEAM_W-1:0] ang_prod;
	logic accept;

	assign cfg_ready = 1'b1;
	assign s_tready = !q_full;
	assign accept = s_tvalid && s_tready;
	assign q_push = accept;
	assign ang_prod = angle_step_q * beam_q;

	always_comb begin
		q_item.range_mm = s_tdata[RANGE_W-1:0];
		q_item.valid = (s_tdata[RANGE_W-1:0] >= range_min_q) &&
			(s_tdata[RANGE_W-1:0] <= range_max_q);
		q_item.last = s_tlast;
		q_item.angle = angle_start_q + ang_prod[ANG_W-1:0];
		q_item.beam = beam_q;
	end

	assign sensor.off_x = off_x_q;
	assign sensor.off_y = off_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_min_q <= '0;
			range_max_q <= '1;
			angle_start_q <= '0;
			angle_step_q <= '0;
			off_x_q <= '0;
			off_y_q <= '0;
			beam_q <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_RANGE_MIN: range_min_q <= cfg_data[RANGE_W-1:0];
					CFG_RANGE_MAX: range_max_q <= cfg_data[RANGE_W-1:0];
					CFG_ANGLE_START: angle_start_q <= cfg_data;
					CFG_ANGLE_STEP: angle_step_q <= cfg_data;
					CFG_OFFSET_X: off_x_q <= cfg_data[OFF_W-1:0];
					CFG_OFFSET_Y: off_y_q <= cfg_data[OFF_W-1:0];
					default: ;
				endcase
			end
			if (accept) begin
				// restart on the last beam, saturate at the top index
				if (s_tlast) begin
					beam_q <= '0;
				end else if (beam_q != BEAM_LAST) begin
					beam_q <= beam_q + 1'b1;
				end
			end
		end
	end

endmodule

### rtl/core/lsn_fifo.sv
// Two-entry queue between the front end and the point engine.
module lsn_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  lsn_pkg::beam_item_t din,
	output logic                full,
	input  logic                pop,
	output lsn_pkg::beam_item_t dout,
	output logic                empty
);
	import lsn_pkg::*;

	beam_item_t mem_q [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign dout = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: ;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue count out of range");
	assert property (@(posedge clk) disable iff (!arst_n) full |-> !push)
		else $error("push into full queue");
	assert property (@(posedge clk) disable iff (!arst_n) empty |-> !pop)
		else $error("pop from empty queue");

endmodule

### rtl/core/lsn_back.sv
// Point engine: shared CORDIC, point window, neighbor search and normal output.
module lsn_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               q_empty,
	input  lsn_pkg::beam_item_t                q_item,
	output logic                               q_pop,
	input  lsn_pkg::sensor_cfg_t               sensor,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [lsn_pkg::OUT_DATA_W-1:0]     m_tdata,
	output logic                               m_tlast
);
	import lsn_pkg::*;

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_ITEM = 5'd1;
	localparam logic [4:0] S_CRUN = 5'd2;
	localparam logic [4:0] S_PMUL = 5'd3;
	localparam logic [4:0] S_PT = 5'd4;
	localparam logic [4:0] S_PLAN = 5'd5;
	localparam logic [4:0] S_LOADC = 5'd6;
	localparam logic [4:0] S_CSEL = 5'd7;
	localparam logic [4:0] S_CSQ = 5'd8;
	localparam logic [4:0] S_CCMP = 5'd9;
	localparam logic [4:0] S_TAN = 5'd10;
	localparam logic [4:0] S_DMUL = 5'd11;
	localparam logic [4:0] S_DCHK = 5'd12;
	localparam logic [4:0] S_VINIT = 5'd13;
	localparam logic [4:0] S_RINIT = 5'd14;
	localparam logic [4:0] S_NRM = 5'd15;
	localparam logic [4:0] S_OUT = 5'd16;
	localparam logic [4:0] S_FIN = 5'd17;

	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);

	logic [4:0] state_q, cret_q;
	beam_item_t item_q;

	logic signed [PT_W-1:0] win_x_q [WIN_N];
	logic signed [PT_W-1:0] win_y_q [WIN_N];
	logic [BEAM_W-1:0] win_b_q [WIN_N];
	logic [WIN_IDX_W-1:0] wn_q, ei_q, elast_q;

	logic signed [CW-1:0] cx_q, cy_q;
	logic signed [ZW-1:0] cz_q;
	logic [STEP_W-1:0] ci_q;
	logic cmode_q;
	logic [1:0] cq_q;
	logic [ANG_W-1:0] cbase_q;

	logic signed [48:0] prod_x_q, prod_y_q;
	logic signed [PT_W-1:0] cur_x_q, cur_y_q, cand_x_q, cand_y_q;
	logic signed [PT_W-1:0] prv_x_q, prv_y_q, nxt_x_q, nxt_y_q;
	logic [BEAM_W-1:0] cur_b_q;
	logic signed [VW-1:0] vx_q, vy_q, ax_q, ay_q;
	logic [1:0] cs_q;
	logic pf_q, nf_q;
	logic signed [DW-1:0] dx_q, dy_q;
	logic signed [GAP_W-1:0] gap_q;
	logic signed [2*DW-1:0] dx2_q, dy2_q;
	logic signed [2*VW-1:0] m1_q, m2_q;
	logic signed [NRM_W-1:0] nx_q, ny_q;
	logic fin_q;

	logic ov_q, olast_q;
	logic [OUT_DATA_W-1:0] odata_q;

	// CORDIC step
	logic signed [CW-1:0] sx, sy, cx_n, cy_n;
	logic signed [ZW-1:0] at_z, cz_n;
	logic cdir;
	// rotation start
	logic [ANG_W-1:0] rot_ang, rot_q2, rot_res;
	logic signed [ZW-1:0] c_full, s_full, xs, ys;
	// point
	logic signed [48:0] sum_x, sum_y;
	logic signed [PT_W-1:0] pt_x, pt_y;
	// window read and candidate
	logic [WIN_IDX_W-1:0] rd_idx, cand_j, k_held, start_i;
	logic signed [PT_W-1:0] rd_x, rd_y;
	logic [BEAM_W-1:0] rd_b;
	logic cside;
	logic [1:0] cstep;
	logic cexists, ctaken;
	logic [2*DW:0] d2;
	logic signed [GAP_W-1:0] gap_lim;
	logic cand_ok;
	// tangent
	logic signed [VW-1:0] tx, ty;
	logic t_found;
	logic signed [2*VW:0] dot;
	logic signed [CW-1:0] vin_x, vin_y;
	logic slot_free;

	function automatic logic signed [VW-1:0] ext_pt(input logic signed [PT_W-1:0] v);
		return {{(VW-PT_W){v[PT_W-1]}}, v};
	endfunction

	assign q_pop = (state_q == S_IDLE) && !q_empty;
	assign m_tvalid = ov_q;
	assign m_tdata = odata_q;
	assign m_tlast = olast_q;
	assign slot_free = !ov_q || m_tready;

	always_comb begin
		sx = cx_q >>> ci_q;
		sy = cy_q >>> ci_q;
		at_z = {{(ZW-ANG_W){1'b0}}, atan_at(ci_q)};
		cdir = cmode_q ? !(cy_q > 0) : !cz_q[ZW-1];
		cx_n = cdir ? cx_q - sy : cx_q + sy;
		cy_n = cdir ? cy_q + sx : cy_q - sx;
		cz_n = cdir ? cz_q - at_z : cz_q + at_z;
	end

	always_comb begin
		rot_ang = (state_q == S_RINIT) ? cbase_q + cz_q[ANG_W-1:0] : item_q.angle;
		rot_q2 = rot_ang + ANG_QUARTER_HALF;
		rot_res = rot_ang - {rot_q2[ANG_W-1:ANG_W-2], {(ANG_W-2){1'b0}}};
		xs = cx_q[ZW-1:0];
		ys = cy_q[ZW-1:0];
		case (cq_q)
			2'd0: begin c_full = xs; s_full = ys; end
			2'd1: begin c_full = -ys; s_full = xs; end
			2'd2: begin c_full = -xs; s_full = -ys; end
			default: begin c_full = ys; s_full = -xs; end
		endcase
	end

	always_comb begin
		sum_x = prod_x_q + (49'sd1 <<< 29);
		sum_y = prod_y_q + (49'sd1 <<< 29);
		pt_x = sum_x[PT_W+29:30] + {{(PT_W-OFF_W){sensor.off_x[OFF_W-1]}}, sensor.off_x};
		pt_y = sum_y[PT_W+29:30] + {{(PT_W-OFF_W){sensor.off_y[OFF_W-1]}}, sensor.off_y};
	end

	always_comb begin
		k_held = item_q.valid ? wn_q - 1'b1 : wn_q;
		start_i = (k_held >= 3'd2) ? k_held - 3'd2 : 3'd0;
		cside = cs_q[1];
		cstep = {1'b0, cs_q[0]} + 2'd1;
		cand_j = cside ? ei_q + {1'b0, cstep} : ei_q - {1'b0, cstep};
		cexists = cside ? ({1'b0, ei_q} + {2'b0, cstep} < {1'b0, wn_q})
			: (ei_q >= {1'b0, cstep});
		ctaken = cside ? nf_q : pf_q;
		rd_idx = (state_q == S_LOADC) ? ei_q : cand_j;
		rd_x = win_x_q[rd_idx];
		rd_y = win_y_q[rd_idx];
		rd_b = win_b_q[rd_idx];
		d2 = {1'b0, dx2_q[2*DW-1:0]} + {1'b0, dy2_q[2*DW-1:0]};
		gap_lim = GAP_W'(cstep) + 12'sd1;
		cand_ok = !(gap_q > gap_lim) &&
			(d2 < (cs_q[0] ? LIM_SQ_FAR : LIM_SQ_NEAR));
	end

	always_comb begin
		t_found = 1'b1;
		if (pf_q && nf_q) begin
			tx = ext_pt(nxt_x_q) - ext_pt(prv_x_q);
			ty = ext_pt(nxt_y_q) - ext_pt(prv_y_q);
		end else if (nf_q) begin
			tx = ext_pt(nxt_x_q) - ext_pt(cur_x_q);
			ty = ext_pt(nxt_y_q) - ext_pt(cur_y_q);
		end else if (pf_q) begin
			tx = ext_pt(cur_x_q) - ext_pt(prv_x_q);
			ty = ext_pt(cur_y_q) - ext_pt(prv_y_q);
		end else begin
			tx = '0;
			ty = '0;
			t_found = 1'b0;
		end
		dot = {m1_q[2*VW-1], m1_q} + {m2_q[2*VW-1], m2_q};
		vin_x = {{(CW-VW-32){ax_q[VW-1]}}, ax_q, 32'b0};
		vin_y = {{(CW-VW-32){ay_q[VW-1]}}, ay_q, 32'b0};
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (!q_empty) begin
					item_q <= q_item;
				end
			end
			S_PMUL: begin
				prod_x_q <= $signed({1'b0, item_q.range_mm}) * $signed(c_full[31:0]);
				prod_y_q <= $signed({1'b0, item_q.range_mm}) * $signed(s_full[31:0]);
			end
			S_PT: begin
				win_x_q[wn_q] <= pt_x;
				win_y_q[wn_q] <= pt_y;
				win_b_q[wn_q] <= item_q.beam;
			end
			S_LOADC: begin
				cur_x_q <= rd_x;
				cur_y_q <= rd_y;
				cur_b_q <= rd_b;
				vx_q <= {{(VW-OFF_W){sensor.off_x[OFF_W-1]}}, sensor.off_x} - ext_pt(rd_x);
				vy_q <= {{(VW-OFF_W){sensor.off_y[OFF_W-1]}}, sensor.off_y} - ext_pt(rd_y);
			end
			S_CSEL: begin
				cand_x_q <= rd_x;
				cand_y_q <= rd_y;
				dx_q <= DW'(ext_pt(rd_x) - ext_pt(cur_x_q));
				dy_q <= DW'(ext_pt(rd_y) - ext_pt(cur_y_q));
				gap_q <= cside ? $signed({1'b0, rd_b}) - $signed({1'b0, cur_b_q})
					: $signed({1'b0, cur_b_q}) - $signed({1'b0, rd_b});
			end
			S_CSQ: begin
				dx2_q <= dx_q * dx_q;
				dy2_q <= dy_q * dy_q;
			end
			S_CCMP: begin
				if (cand_ok && !cside) begin
					prv_x_q <= cand_x_q;
					prv_y_q <= cand_y_q;
				end
				if (cand_ok && cside) begin
					nxt_x_q <= cand_x_q;
					nxt_y_q <= cand_y_q;
				end
			end
			S_TAN: begin
				if (t_found && (tx != 0 || ty != 0)) begin
					ax_q <= -ty;
					ay_q <= tx;
				end else begin
					ax_q <= vx_q;
					ay_q <= vy_q;
				end
				nx_q <= '0;
				ny_q <= NRM_ONE;
			end
			S_DMUL: begin
				m1_q <= ax_q * vx_q;
				m2_q <= ay_q * vy_q;
			end
			S_DCHK: begin
				// face the sensor
				if (dot < 0) begin
					ax_q <= -ax_q;
					ay_q <= -ay_q;
				end
			end
			S_NRM: begin
				nx_q <= to_q14(c_full);
				ny_q <= to_q14(s_full);
			end
			S_FIN: begin
				if (!item_q.last && wn_q == WIN_IDX_W'(WIN_N)) begin
					for (int p = 0; p < WIN_N - 1; p++) begin
						win_x_q[p] <= win_x_q[p+1];
						win_y_q[p] <= win_y_q[p+1];
						win_b_q[p] <= win_b_q[p+1];
					end
				end
			end
			default: ;
		endcase
		if (state_q == S_OUT && slot_free) begin
			odata_q <= {1'b0, cur_b_q, ny_q, nx_q, cur_y_q, cur_x_q};
			olast_q <= fin_q && (ei_q == elast_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cret_q <= S_IDLE;
			wn_q <= '0;
			ei_q <= '0;
			elast_q <= '0;
			cs_q <= '0;
			pf_q <= 1'b0;
			nf_q <= 1'b0;
			fin_q <= 1'b0;
			ov_q <= 1'b0;
			ci_q <= '0;
			cmode_q <= 1'b0;
			cq_q <= '0;
			cbase_q <= '0;
			cx_q <= '0;
			cy_q <= '0;
			cz_q <= '0;
		end else begin
			// load a new result, or hold the one still waiting
			ov_q <= (state_q == S_OUT && slot_free) || (ov_q && !m_tready);
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						state_q <= S_ITEM;
					end
				end
				S_ITEM: begin
					if (item_q.valid) begin
						cx_q <= CORDIC_K;
						cy_q <= '0;
						cz_q <= {{(ZW-ANG_W){rot_res[ANG_W-1]}}, rot_res};
						cq_q <= rot_q2[ANG_W-1:ANG_W-2];
						cmode_q <= 1'b0;
						ci_q <= '0;
						cret_q <= S_PMUL;
						state_q <= S_CRUN;
					end else begin
						state_q <= S_PLAN;
					end
				end
				S_CRUN: begin
					cx_q <= cx_n;
					cy_q <= cy_n;
					cz_q <= cz_n;
					ci_q <= ci_q + 1'b1;
					if (ci_q == STEP_LAST) begin
						state_q <= cret_q;
					end
				end
				S_PMUL: state_q <= S_PT;
				S_PT: begin
					wn_q <= wn_q + 1'b1;
					state_q <= S_PLAN;
				end
				S_PLAN: begin
					if (item_q.last) begin
						if (wn_q > start_i) begin
							ei_q <= start_i;
							elast_q <= wn_q - 1'b1;
							fin_q <= 1'b1;
							state_q <= S_LOADC;
						end else begin
							state_q <= S_FIN;
						end
					end else if (item_q.valid && k_held >= 3'd2) begin
						ei_q <= k_held - 3'd2;
						elast_q <= k_held - 3'd2;
						fin_q <= 1'b0;
						state_q <= S_LOADC;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_LOADC: begin
					cs_q <= '0;
					pf_q <= 1'b0;
					nf_q <= 1'b0;
					state_q <= S_CSEL;
				end
				S_CSEL: begin
					if (cexists && !ctaken) begin
						state_q <= S_CSQ;
					end else if (cs_q == 2'd3) begin
						state_q <= S_TAN;
					end else begin
						cs_q <= cs_q + 1'b1;
					end
				end
				S_CSQ: state_q <= S_CCMP;
				S_CCMP: begin
					if (cand_ok && !cside) begin
						pf_q <= 1'b1;
					end
					if (cand_ok && cside) begin
						nf_q <= 1'b1;
					end
					if (cs_q == 2'd3) begin
						state_q <= S_TAN;
					end else begin
						cs_q <= cs_q + 1'b1;
						state_q <= S_CSEL;
					end
				end
				S_TAN: begin
					if (t_found && (tx != 0 || ty != 0)) begin
						state_q <= S_DMUL;
					end else if (vx_q != 0 || vy_q != 0) begin
						state_q <= S_VINIT;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_DMUL: state_q <= S_DCHK;
				S_DCHK: state_q <= S_VINIT;
				S_VINIT: begin
					if (ax_q < 0) begin
						cx_q <= -vin_x;
						cy_q <= -vin_y;
						cbase_q <= ANG_HALF_TURN;
					end else begin
						cx_q <= vin_x;
						cy_q <= vin_y;
						cbase_q <= '0;
					end
					cz_q <= '0;
					cmode_q <= 1'b1;
					ci_q <= '0;
					cret_q <= S_RINIT;
					state_q <= S_CRUN;
				end
				S_RINIT: begin
					cx_q <= CORDIC_K;
					cy_q <= '0;
					cz_q <= {{(ZW-ANG_W){rot_res[ANG_W-1]}}, rot_res};
					cq_q <= rot_q2[ANG_W-1:ANG_W-2];
					cmode_q <= 1'b0;
					ci_q <= '0;
					cret_q <= S_NRM;
					state_q <= S_CRUN;
				end
				S_NRM: state_q <= S_OUT;
				S_OUT: begin
					if (slot_free) begin
						if (ei_q == elast_q) begin
							state_q <= S_FIN;
						end else begin
							ei_q <= ei_q + 1'b1;
							state_q <= S_LOADC;
						end
					end
				end
				S_FIN: begin
					if (item_q.last) begin
						wn_q <= '0;
					end else if (wn_q == WIN_IDX_W'(WIN_N)) begin
						wn_q <= WIN_IDX_W'(WIN_N - 1);
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) wn_q <= WIN_IDX_W'(WIN_N))
		else $error("window count out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOADC) |-> (ei_q < wn_q))
		else $error("emitted point outside window");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CRUN) |-> (ci_q <= STEP_LAST))
		else $error("CORDIC step count overrun");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && ov_q && !m_tready) |=> (state_q == S_OUT))
		else $error("result dropped while output stalled");

endmodule

### rtl/core/lidar_scan_points_and_normals.sv
// Top level of the lidar scan point and normal block.
// Beams enter through a combinational front end into a two-entry queue; the point engine behind it
// handles one beam at a time. A beam out of range skips the CORDIC, an in-range beam takes one
// 30-step CORDIC rotation plus setup, and each emitted point adds the neighbor checks and up to two
// 30-step passes of the shared CORDIC. A scan end flushes up to three points. The shared CORDIC
// sets the throughput; the output register lets the engine finish a point while the previous one
// waits to be taken.
module lidar_scan_points_and_normals (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [lsn_pkg::IN_DATA_W-1:0]      s_tdata,  // [15:0] range_mm
	input  logic                               s_tlast,  // scan_end
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [17:0] point_x, [35:18] point_y, [51:36] normal_x, [67:52] normal_y,
	// [78:68] source_beam, [79] zero
	output logic [lsn_pkg::OUT_DATA_W-1:0]     m_tdata,
	output logic                               m_tlast,  // final_point
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [lsn_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lsn_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import lsn_pkg::*;

	beam_item_t push_item, pop_item;
	sensor_cfg_t sensor;
	logic q_push, q_pop, q_full, q_empty;

	lsn_front u_front (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.q_full(q_full), .q_push(q_push), .q_item(push_item), .sensor(sensor)
	);

	lsn_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(q_push), .din(push_item), .full(q_full),
		.pop(q_pop), .dout(pop_item), .empty(q_empty)
	);

	lsn_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_empty(q_empty), .q_item(pop_item), .q_pop(q_pop), .sensor(sensor),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

endmodule
